>>> src/color_shade_hls_defines.svh
`ifndef COLOR_SHADE_HLS_DEFINES_SVH
`define COLOR_SHADE_HLS_DEFINES_SVH

// same-cycle implication under the block clock and reset
`define CSH_ASSERT_NOW(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("csh assertion failed");

// next-cycle implication under the block clock and reset
`define CSH_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("csh assertion failed");

`endif

>>> src/csh_pkg.sv
package csh_pkg;

    localparam int unsigned CH_W     = 16;
    localparam int unsigned DIV_W    = 16;
    localparam int unsigned FACT_W   = 16;
    localparam int unsigned HUE_W    = 17;
    localparam int unsigned NUM_LANE = 3;

    localparam logic [16:0] UNIT_ONE  = 17'd65535;
    localparam logic [16:0] DEG60     = 17'd15360;
    localparam logic [16:0] DEG120    = 17'd30720;
    localparam logic [16:0] DEG180    = 17'd46080;
    localparam logic [16:0] DEG240    = 17'd61440;
    localparam logic [16:0] DEG360    = 17'd92160;
    localparam logic [15:0] FACT_ONE  = 16'd4096;
    localparam logic [16:0] RECIP15   = 17'd69905;

    // which channel was largest, sets the hue base
    typedef enum logic [1:0] {
        HUE_RED,
        HUE_GREEN,
        HUE_BLUE
    } hue_sel_t;

    // fields that ride along with the two dividers
    typedef struct packed {
        logic [CH_W-1:0] lit;
        logic            d_zero;
        hue_sel_t        sel;
        logic            neg;
    } side_t;

endpackage

>>> src/csh_front.sv
module csh_front
    import csh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ce,
    input  logic                  vin,
    input  logic [CH_W-1:0]       red,
    input  logic [CH_W-1:0]       green,
    input  logic [CH_W-1:0]       blue,
    output logic                  vout,
    output logic [2*DIV_W-1:0]    sat_num,
    output logic [DIV_W-1:0]      sat_den,
    output logic [2*DIV_W-1:0]    hue_num,
    output logic [DIV_W-1:0]      hue_den,
    output side_t                 side
);

    // stage one: max, min, hue selector, signed channel difference
    logic                v1_reg;
    logic [CH_W-1:0]     mx_reg, mn_reg, mx_next, mn_next;
    hue_sel_t            sel_reg, sel_next;
    logic signed [16:0]  diff_reg, diff_next;

    always_comb
    begin
        mx_next = red;
        if (green > mx_next)
            mx_next = green;
        if (blue > mx_next)
            mx_next = blue;
        mn_next = red;
        if (green < mn_next)
            mn_next = green;
        if (blue < mn_next)
            mn_next = blue;
        if (red == mx_next)
        begin
            sel_next  = HUE_RED;
            diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
        end
        else if (green == mx_next)
        begin
            sel_next  = HUE_GREEN;
            diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
        end
        else
        begin
            sel_next  = HUE_BLUE;
            diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (ce)
            v1_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            mx_reg   <= mx_next;
            mn_reg   <= mn_next;
            sel_reg  <= sel_next;
            diff_reg <= diff_next;
        end
    end

    // stage two: dividend and divisor for saturation and hue
    logic                v2_reg;
    logic [DIV_W-1:0]    d_w, mag_w;
    logic [16:0]         sum_w, den_full;
    logic [2*DIV_W-1:0]  sat_num_reg, hue_num_reg;
    logic [DIV_W-1:0]    sat_den_reg, hue_den_reg;
    side_t               side_reg, side_next;

    always_comb
    begin
        d_w   = mx_reg - mn_reg;
        sum_w = {1'b0, mx_reg} + {1'b0, mn_reg};
        if (sum_w <= UNIT_ONE)
            den_full = sum_w;
        else
            den_full = (UNIT_ONE << 1) - sum_w;
        if (diff_reg < 0)
            mag_w = 16'(-diff_reg);
        else
            mag_w = diff_reg[15:0];
        side_next.lit    = sum_w[16:1];
        side_next.d_zero = (d_w == '0);
        side_next.sel    = sel_reg;
        side_next.neg    = diff_reg[16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (ce)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            sat_num_reg <= {d_w, 16'd0} - {16'd0, d_w};
            sat_den_reg <= den_full[15:0];
            hue_num_reg <= {2'd0, mag_w, 14'd0} - {6'd0, mag_w, 10'd0};
            hue_den_reg <= d_w;
            side_reg    <= side_next;
        end
    end

    assign vout    = v2_reg;
    assign sat_num = sat_num_reg;
    assign sat_den = sat_den_reg;
    assign hue_num = hue_num_reg;
    assign hue_den = hue_den_reg;
    assign side    = side_reg;

endmodule

>>> src/csh_div.sv
module csh_div
    import csh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ce,
    input  logic                  vin,
    input  logic [2*DIV_W-1:0]    sat_num,
    input  logic [DIV_W-1:0]      sat_den,
    input  logic [2*DIV_W-1:0]    hue_num,
    input  logic [DIV_W-1:0]      hue_den,
    input  side_t                 side_in,
    output logic                  vout,
    output logic [DIV_W-1:0]      sat_q,
    output logic [DIV_W-1:0]      hue_q,
    output side_t                 side_out
);

    // restoring division, one quotient bit per stage, both lanes side by side
    logic             v_reg   [DIV_W];
    logic [DIV_W-1:0] srem_reg [DIV_W], slow_reg [DIV_W], sq_reg [DIV_W], sdiv_reg [DIV_W];
    logic [DIV_W-1:0] hrem_reg [DIV_W], hlow_reg [DIV_W], hq_reg [DIV_W], hdiv_reg [DIV_W];
    side_t            side_reg [DIV_W];

    genvar k;
    generate
        for (k = 0; k < DIV_W; k++)
        begin : g_stage
            logic             v_cur;
            logic [DIV_W-1:0] srem, slow, sq, sdiv, hrem, hlow, hq, hdiv;
            side_t            sd;
            logic [DIV_W:0]   strial, htrial;
            logic             sge, hge;

            if (k == 0)
            begin : g_first
                assign v_cur = vin;
                assign srem  = sat_num[2*DIV_W-1:DIV_W];
                assign slow  = sat_num[DIV_W-1:0];
                assign sq    = '0;
                assign sdiv  = sat_den;
                assign hrem  = hue_num[2*DIV_W-1:DIV_W];
                assign hlow  = hue_num[DIV_W-1:0];
                assign hq    = '0;
                assign hdiv  = hue_den;
                assign sd    = side_in;
            end
            else
            begin : g_next
                assign v_cur = v_reg[k-1];
                assign srem  = srem_reg[k-1];
                assign slow  = slow_reg[k-1];
                assign sq    = sq_reg[k-1];
                assign sdiv  = sdiv_reg[k-1];
                assign hrem  = hrem_reg[k-1];
                assign hlow  = hlow_reg[k-1];
                assign hq    = hq_reg[k-1];
                assign hdiv  = hdiv_reg[k-1];
                assign sd    = side_reg[k-1];
            end

            assign strial = {srem, slow[DIV_W-1]};
            assign htrial = {hrem, hlow[DIV_W-1]};
            assign sge    = (strial >= {1'b0, sdiv});
            assign hge    = (htrial >= {1'b0, hdiv});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (ce)
                    v_reg[k] <= v_cur;
            end

            always_ff @(posedge clk)
            begin
                if (ce)
                begin
                    srem_reg[k] <= sge ? DIV_W'(strial - {1'b0, sdiv}) : strial[DIV_W-1:0];
                    slow_reg[k] <= {slow[DIV_W-2:0], 1'b0};
                    sq_reg[k]   <= {sq[DIV_W-2:0], sge};
                    sdiv_reg[k] <= sdiv;
                    hrem_reg[k] <= hge ? DIV_W'(htrial - {1'b0, hdiv}) : htrial[DIV_W-1:0];
                    hlow_reg[k] <= {hlow[DIV_W-2:0], 1'b0};
                    hq_reg[k]   <= {hq[DIV_W-2:0], hge};
                    hdiv_reg[k] <= hdiv;
                    side_reg[k] <= sd;
                end
            end
        end
    endgenerate

    assign vout     = v_reg[DIV_W-1];
    assign sat_q    = sq_reg[DIV_W-1];
    assign hue_q    = hq_reg[DIV_W-1];
    assign side_out = side_reg[DIV_W-1];

endmodule

>>> src/csh_back.sv
module csh_back
    import csh_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  ce,
    input  logic                  vin,
    input  logic [DIV_W-1:0]      sat_q,
    input  logic [DIV_W-1:0]      hue_q,
    input  side_t                 side,
    input  logic [FACT_W-1:0]     factor,
    output logic                  vout,
    output logic [CH_W-1:0]       red,
    output logic [CH_W-1:0]       green,
    output logic [CH_W-1:0]       blue
);

    logic [8:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (ce)
            v_reg <= {v_reg[7:0], vin};
    end

    // s3: finished hue, lightness and saturation times factor
    logic signed [17:0] hbase, hsum;
    logic [HUE_W-1:0]   hue3_reg;
    logic [31:0]        lprod_reg, sprod_reg;

    always_comb
    begin
        case (side.sel)
            HUE_RED:   hbase = 18'sd0;
            HUE_GREEN: hbase = $signed({1'b0, DEG120});
            default:   hbase = $signed({1'b0, DEG240});
        endcase
        if (side.neg)
            hsum = hbase - $signed({2'b0, hue_q});
        else
            hsum = hbase + $signed({2'b0, hue_q});
        if (side.d_zero)
            hsum = 18'sd0;
        else if (hsum < 0)
            hsum = hsum + $signed({1'b0, DEG360});
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            hue3_reg  <= hsum[HUE_W-1:0];
            lprod_reg <= side.lit * factor;
            sprod_reg <= (side.d_zero ? 16'd0 : sat_q) * factor;
        end
    end

    // s4: rescale and saturate to one
    logic [CH_W-1:0]  l4_reg, s4_reg;
    logic [HUE_W-1:0] hue4_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            l4_reg   <= (lprod_reg[31:28] != '0) ? 16'hFFFF : lprod_reg[27:12];
            s4_reg   <= (sprod_reg[31:28] != '0) ? 16'hFFFF : sprod_reg[27:12];
            hue4_reg <= hue3_reg;
        end
    end

    // s5: lightness times saturation
    logic [CH_W-1:0]  l5_reg, s5_reg;
    logic [HUE_W-1:0] hue5_reg;
    logic [31:0]      ls5_reg;
    logic             gray5_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            l5_reg    <= l4_reg;
            s5_reg    <= s4_reg;
            hue5_reg  <= hue4_reg;
            ls5_reg   <= l4_reg * s4_reg;
            gray5_reg <= (s4_reg == '0);
        end
    end

    // s6: divide by 65535, high half plus one-step correction
    logic [16:0]      prem;
    logic [CH_W-1:0]  p6_reg, l6_reg, s6_reg;
    logic [HUE_W-1:0] hue6_reg;
    logic             gray6_reg;

    assign prem = {1'b0, ls5_reg[15:0]} + {1'b0, ls5_reg[31:16]};

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            p6_reg    <= ls5_reg[31:16] + {15'd0, (prem >= UNIT_ONE)};
            l6_reg    <= l5_reg;
            s6_reg    <= s5_reg;
            hue6_reg  <= hue5_reg;
            gray6_reg <= gray5_reg;
        end
    end

    // s7: m2 and m1
    logic [17:0]        m2_raw;
    logic [CH_W-1:0]    m2_w, m1_w;
    logic signed [18:0] m1_raw;
    logic [CH_W-1:0]    m1_7_reg, m2_7_reg, l7_reg;
    logic [HUE_W-1:0]   hue7_reg;
    logic               gray7_reg;

    always_comb
    begin
        if ({l6_reg, 1'b0} <= UNIT_ONE)
            m2_raw = {2'd0, l6_reg} + {2'd0, p6_reg};
        else
            m2_raw = {2'd0, l6_reg} + {2'd0, s6_reg} - {2'd0, p6_reg};
        m2_w   = (m2_raw > {1'b0, UNIT_ONE}) ? 16'hFFFF : m2_raw[15:0];
        m1_raw = $signed({2'd0, l6_reg, 1'b0}) - $signed({3'd0, m2_w});
        if (m1_raw < 0)
            m1_w = '0;
        else if (m1_raw > $signed({2'd0, UNIT_ONE}))
            m1_w = 16'hFFFF;
        else
            m1_w = m1_raw[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            m1_7_reg  <= m1_w;
            m2_7_reg  <= m2_w;
            l7_reg    <= l6_reg;
            hue7_reg  <= hue6_reg;
            gray7_reg <= gray6_reg;
        end
    end

    // s8: per-channel hue and ramp position (0 gives m1, 60 deg gives m2)
    logic signed [18:0]            lane_off [NUM_LANE];
    logic signed [18:0]            ch_hue   [NUM_LANE];
    logic [NUM_LANE-1:0][14:0]     t_next, t8_reg;
    logic [CH_W-1:0]               m1_8_reg, dm8_reg, l8_reg;
    logic                          gray8_reg;

    assign lane_off[0] = $signed({2'd0, DEG120});
    assign lane_off[1] = 19'sd0;
    assign lane_off[2] = -$signed({2'd0, DEG120});

    always_comb
    begin
        for (int i = 0; i < NUM_LANE; i++)
        begin
            ch_hue[i] = $signed({2'd0, hue7_reg}) + lane_off[i];
            if (ch_hue[i] > $signed({2'd0, DEG360}))
                ch_hue[i] = ch_hue[i] - $signed({2'd0, DEG360});
            if (ch_hue[i] < 0)
                ch_hue[i] = ch_hue[i] + $signed({2'd0, DEG360});
            if (ch_hue[i] < $signed({2'd0, DEG60}))
                t_next[i] = ch_hue[i][14:0];
            else if (ch_hue[i] < $signed({2'd0, DEG180}))
                t_next[i] = DEG60[14:0];
            else if (ch_hue[i] < $signed({2'd0, DEG240}))
                t_next[i] = 15'($signed({2'd0, DEG240}) - ch_hue[i]);
            else
                t_next[i] = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            t8_reg    <= t_next;
            m1_8_reg  <= m1_7_reg;
            dm8_reg   <= m2_7_reg - m1_7_reg;
            l8_reg    <= l7_reg;
            gray8_reg <= gray7_reg;
        end
    end

    // s9: span times ramp position, then drop the 1024 factor of 15360
    logic [NUM_LANE-1:0][19:0] y9_reg;
    logic [CH_W-1:0]           m1_9_reg, l9_reg;
    logic                      gray9_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < NUM_LANE; i++)
                y9_reg[i] <= 20'(({14'd0, dm8_reg} * {15'd0, t8_reg[i]}) >> 10);
            m1_9_reg  <= m1_8_reg;
            l9_reg    <= l8_reg;
            gray9_reg <= gray8_reg;
        end
    end

    // s10: divide by 15 with a reciprocal
    logic [NUM_LANE-1:0][36:0] ky10_reg;
    logic [NUM_LANE-1:0][19:0] y10_reg;
    logic [CH_W-1:0]           m1_10_reg, l10_reg;
    logic                      gray10_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < NUM_LANE; i++)
                ky10_reg[i] <= y9_reg[i] * RECIP15;
            y10_reg    <= y9_reg;
            m1_10_reg  <= m1_9_reg;
            l10_reg    <= l9_reg;
            gray10_reg <= gray9_reg;
        end
    end

    // s11: quotient correction, offset by m1, saturate, output register
    logic [NUM_LANE-1:0][16:0]     q0, qf;
    logic [NUM_LANE-1:0][20:0]     rr;
    logic [NUM_LANE-1:0][17:0]     vsum;
    logic [NUM_LANE-1:0][CH_W-1:0] res_next, res_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_LANE; i++)
        begin
            q0[i]   = ky10_reg[i][36:20];
            rr[i]   = {1'b0, y10_reg[i]} - 21'(q0[i] * 5'd15);
            qf[i]   = q0[i] + {16'd0, (rr[i] >= 21'd15)};
            vsum[i] = {2'd0, m1_10_reg} + {1'b0, qf[i]};
            if (gray10_reg)
                res_next[i] = l10_reg;
            else if (vsum[i] > {1'b0, UNIT_ONE})
                res_next[i] = 16'hFFFF;
            else
                res_next[i] = vsum[i][15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
            res_reg <= res_next;
    end

    assign vout  = v_reg[8];
    assign red   = res_reg[0];
    assign green = res_reg[1];
    assign blue  = res_reg[2];

endmodule

>>> src/color_shade_hls.sv
// an input transfer passes the front, divider and back stages to the master side
// throughput: one color per clock; the pipeline advances as a whole and holds
// only while a finished result waits on the master side
// reset: asynchronous active low, clears all valid bits, shade_factor to 1.0
`include "color_shade_hls_defines.svh"

module color_shade_hls
    import csh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // slave side: [15:0] in_red, [31:16] in_green, [47:32] in_blue
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,
    // master side: [15:0] out_red, [31:16] out_green, [47:32] out_blue
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata,
    // shade_factor write channel, unsigned q4.12
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [15:0]  cfg_data
);

    // shade factor register, always ready to take a write
    logic [FACT_W-1:0] shade_factor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            shade_factor_reg <= FACT_ONE;
        else if (cfg_valid)
            shade_factor_reg <= cfg_data;
    end

    assign cfg_ready = 1'b1;

    // one clock enable for every stage: move unless the output is blocked
    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // front end: max/min, hue sector, divider operands (2 stages)
    logic               f_valid;
    logic [2*DIV_W-1:0] f_sat_num, f_hue_num;
    logic [DIV_W-1:0]   f_sat_den, f_hue_den;
    side_t              f_side;

    csh_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .ce      (ce),
        .vin     (s_tvalid),
        .red     (s_tdata[15:0]),
        .green   (s_tdata[31:16]),
        .blue    (s_tdata[47:32]),
        .vout    (f_valid),
        .sat_num (f_sat_num),
        .sat_den (f_sat_den),
        .hue_num (f_hue_num),
        .hue_den (f_hue_den),
        .side    (f_side)
    );

    // saturation and hue quotients, one bit per stage (16 stages)
    logic             d_valid;
    logic [DIV_W-1:0] d_sat_q, d_hue_q;
    side_t            d_side;

    csh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ce       (ce),
        .vin      (f_valid),
        .sat_num  (f_sat_num),
        .sat_den  (f_sat_den),
        .hue_num  (f_hue_num),
        .hue_den  (f_hue_den),
        .side_in  (f_side),
        .vout     (d_valid),
        .sat_q    (d_sat_q),
        .hue_q    (d_hue_q),
        .side_out (d_side)
    );

    // shading and conversion back to rgb, ends in the output register (9 stages)
    logic [CH_W-1:0] o_red, o_green, o_blue;

    csh_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .ce     (ce),
        .vin    (d_valid),
        .sat_q  (d_sat_q),
        .hue_q  (d_hue_q),
        .side   (d_side),
        .factor (shade_factor_reg),
        .vout   (m_tvalid),
        .red    (o_red),
        .green  (o_green),
        .blue   (o_blue)
    );

    assign m_tdata = {o_blue, o_green, o_red};

    // input side may only take a transfer when the pipeline can move
    `CSH_ASSERT_NOW(a_ready_follows_output, s_tvalid && s_tready, !m_tvalid || m_tready)
    // a write lands in the factor register on the next edge
    `CSH_ASSERT_NEXT(a_cfg_write, cfg_valid && cfg_ready, shade_factor_reg == $past(cfg_data))
    // a blocked output freezes the whole pipeline; the factor still takes writes
    `CSH_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready && !cfg_valid,
                     $stable(shade_factor_reg) && m_tvalid)

endmodule
